// ----- hdl/sgd_pkg.sv -----
// shared types and constants of the shake gesture detector
package sgd_pkg;

  localparam int COUNT_W = 3;
  localparam int THR_W = 32;
  localparam int MS_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int QUEUE_DEPTH = 4;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED = 2'd3;

  // register values after reset
  localparam logic [THR_W-1:0] THRESHOLD_RST = 32'd489205924;
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd500;
  localparam logic [MS_W-1:0] WINDOW_RST = 16'd3000;
  localparam logic [COUNT_W-1:0] REQUIRED_RST = 3'd3;

  // item kind carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_HOLD = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic kind;
    logic held;
    logic over;
  } sgd_class_t;

  localparam int CLASS_W = $bits(sgd_class_t);

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] window_ms;
    logic [COUNT_W-1:0] shakes_required;
  } sgd_cfg_t;

  // result bits, sos_trigger lowest
  typedef struct packed {
    logic [COUNT_W-1:0] shakes_so_far;
    logic shake_accepted;
    logic sos_trigger;
  } sgd_result_t;

endpackage

// ----- hdl/shake_gesture_detector_top.sv -----
// top level of the shake gesture detector: configuration registers and stream ports
// Takes one request per cycle while s_tready is high (accelerometer sample or hold
// change, selected by s_tuser) and returns exactly one result per request, in order.
// The squaring stage registers a request as it is taken, the queue then stores it,
// and the result register fed by the counter logic captures its result as the queue
// pops it. Sustained rate is one request per clock while m_tready stays high; the
// four-entry queue lets the squaring front keep taking requests while m_tready is
// low, until the queue fills. Configuration writes take effect on the next clock and
// are to be made only while no request is in flight.
module shake_gesture_detector_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // accel_x, accel_y, accel_z, timestamp_ms, held, zero fill
  input  logic [((3 * SAMPLE_WIDTH + TIME_WIDTH + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  // kind
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // sos_trigger, shake_accepted, shakes_so_far, zero fill
  output logic [sgd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic cfg_we,
  input  logic [sgd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int Y_LSB = SAMPLE_WIDTH;
  localparam int Z_LSB = 2 * SAMPLE_WIDTH;
  localparam int T_LSB = 3 * SAMPLE_WIDTH;
  localparam int H_BIT = 3 * SAMPLE_WIDTH + TIME_WIDTH;
  localparam int ENTRY_W = TIME_WIDTH + sgd_pkg::CLASS_W;

  logic [sgd_pkg::THR_W-1:0] threshold_squared;
  sgd_pkg::sgd_cfg_t cfg;

  logic push_valid;
  logic push_ready;
  sgd_pkg::sgd_class_t push_class;
  logic [TIME_WIDTH-1:0] push_time;
  logic q_valid;
  logic q_ready;
  logic [ENTRY_W-1:0] q_data;
  sgd_pkg::sgd_class_t q_class;
  logic [TIME_WIDTH-1:0] q_time;
  sgd_pkg::sgd_result_t out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_squared <= sgd_pkg::THRESHOLD_RST;
      cfg.debounce_ms <= sgd_pkg::DEBOUNCE_RST;
      cfg.window_ms <= sgd_pkg::WINDOW_RST;
      cfg.shakes_required <= sgd_pkg::REQUIRED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgd_pkg::REG_THRESHOLD: threshold_squared <= cfg_data[sgd_pkg::THR_W-1:0];
        sgd_pkg::REG_DEBOUNCE: cfg.debounce_ms <= cfg_data[sgd_pkg::MS_W-1:0];
        sgd_pkg::REG_WINDOW: cfg.window_ms <= cfg_data[sgd_pkg::MS_W-1:0];
        sgd_pkg::REG_REQUIRED: cfg.shakes_required <= cfg_data[sgd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  sgd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .kind(s_tuser),
    .accel_x(s_tdata[Y_LSB-1:0]),
    .accel_y(s_tdata[Z_LSB-1:Y_LSB]),
    .accel_z(s_tdata[T_LSB-1:Z_LSB]),
    .timestamp_ms(s_tdata[H_BIT-1:T_LSB]),
    .held(s_tdata[H_BIT]),
    .threshold_squared(threshold_squared),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_class(push_class),
    .push_time(push_time)
  );

  sgd_queue #(
    .DATA_W(ENTRY_W),
    .DEPTH(sgd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data({push_time, push_class}),
    .pop_valid(q_valid),
    .pop_ready(q_ready),
    .pop_data(q_data)
  );

  assign q_class = q_data[sgd_pkg::CLASS_W-1:0];
  assign q_time = q_data[ENTRY_W-1:sgd_pkg::CLASS_W];

  sgd_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_class(q_class),
    .q_time(q_time),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_result(out_result)
  );

  assign m_tdata = sgd_pkg::OUT_TDATA_W'(out_result);

endmodule

// ----- hdl/sgd_front.sv -----
// front part: takes requests, squares the axes and classifies against the threshold
module sgd_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic kind,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
  input  logic [TIME_WIDTH-1:0] timestamp_ms,
  input  logic held,
  input  logic [sgd_pkg::THR_W-1:0] threshold_squared,
  output logic push_valid,
  input  logic push_ready,
  output sgd_pkg::sgd_class_t push_class,
  output logic [TIME_WIDTH-1:0] push_time
);

  localparam int SQ_W = 2 * SAMPLE_WIDTH - 1;
  localparam int MAG_W = 2 * SAMPLE_WIDTH;
  localparam int CMP_W = (MAG_W > sgd_pkg::THR_W) ? MAG_W : sgd_pkg::THR_W;

  logic s1_valid;
  logic s1_kind;
  logic s1_held;
  logic [TIME_WIDTH-1:0] s1_time;
  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic [SQ_W-1:0] sq_z;
  logic signed [MAG_W-1:0] prod_x;
  logic signed [MAG_W-1:0] prod_y;
  logic signed [MAG_W-1:0] prod_z;
  logic [MAG_W-1:0] mag2;
  logic accept;

  assign in_ready = !s1_valid || push_ready;
  assign accept = in_valid && in_ready;

  assign prod_x = accel_x * accel_x;
  assign prod_y = accel_y * accel_y;
  assign prod_z = accel_z * accel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind;
      s1_held <= held;
      s1_time <= timestamp_ms;
      // a square is never negative, its top bit is always clear
      sq_x <= SQ_W'(prod_x);
      sq_y <= SQ_W'(prod_y);
      sq_z <= SQ_W'(prod_z);
    end
  end

  assign mag2 = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);

  assign push_valid = s1_valid;
  assign push_class.kind = s1_kind;
  assign push_class.held = s1_held;
  assign push_class.over = CMP_W'(mag2) > CMP_W'(threshold_squared);
  assign push_time = s1_time;

endmodule

// ----- hdl/sgd_queue.sv -----
// short queue between the front and back parts
module sgd_queue #(
  parameter int DATA_W = 35,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

// ----- hdl/sgd_back.sv -----
// back part: hold state, shake counter, debounce and window, result register
module sgd_back #(
  parameter int TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  sgd_pkg::sgd_cfg_t cfg,
  input  logic q_valid,
  output logic q_ready,
  input  sgd_pkg::sgd_class_t q_class,
  input  logic [TIME_WIDTH-1:0] q_time,
  output logic out_valid,
  input  logic out_ready,
  output sgd_pkg::sgd_result_t out_result
);

  logic hold_flag;
  logic hold_flag_next;
  logic [sgd_pkg::COUNT_W-1:0] shake_counter;
  logic [sgd_pkg::COUNT_W-1:0] shake_counter_next;
  logic [TIME_WIDTH-1:0] last_shake_ms;
  logic [TIME_WIDTH-1:0] last_shake_ms_next;
  logic [TIME_WIDTH-1:0] gap;
  logic [sgd_pkg::COUNT_W-1:0] base;
  logic [sgd_pkg::COUNT_W-1:0] bumped;
  sgd_pkg::sgd_result_t result;
  logic pop;

  assign q_ready = !out_valid || out_ready;
  assign pop = q_valid && q_ready;

  // wrapping difference since the last counted shake
  assign gap = q_time - last_shake_ms;

  always_comb begin
    hold_flag_next = hold_flag;
    shake_counter_next = shake_counter;
    last_shake_ms_next = last_shake_ms;
    result = '0;
    base = shake_counter;
    bumped = '0;
    if (q_class.kind == sgd_pkg::KIND_HOLD) begin
      hold_flag_next = q_class.held;
      if (!q_class.held) begin
        shake_counter_next = '0;
      end
    end else if (hold_flag && q_class.over && gap > TIME_WIDTH'(cfg.debounce_ms)) begin
      if (gap > TIME_WIDTH'(cfg.window_ms)) begin
        base = '0;
      end
      bumped = base + 1'b1;
      last_shake_ms_next = q_time;
      result.shake_accepted = 1'b1;
      if (bumped >= cfg.shakes_required) begin
        shake_counter_next = '0;
        result.sos_trigger = 1'b1;
      end else begin
        shake_counter_next = bumped;
      end
    end
    result.shakes_so_far = shake_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_flag <= 1'b0;
      shake_counter <= '0;
      last_shake_ms <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        hold_flag <= hold_flag_next;
        shake_counter <= shake_counter_next;
        last_shake_ms <= last_shake_ms_next;
      end
      if (q_ready) begin
        out_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result;
    end
  end

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    !hold_flag |-> shake_counter == '0)
    else $error("shake count kept while not held");

  a_trigger_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.sos_trigger) |->
      (out_result.shake_accepted && out_result.shakes_so_far == '0))
    else $error("trigger without a counted shake or with count left");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && out_result.shakes_so_far == shake_counter)
    else $error("reported count differs from the counter");

endmodule
